// ----- rtl/skvt_pkg.sv -----
package skvt_pkg;

	// Table geometry
	localparam int DEPTH       = 16;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 5;

	// Configuration port
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 5;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SIGNED   = 2'd1;

	// Commands
	localparam logic [1:0] CMD_PUT    = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	// Get match rules
	localparam logic [2:0] COND_EQ = 3'd0;
	localparam logic [2:0] COND_LT = 3'd1;
	localparam logic [2:0] COND_LE = 3'd2;
	localparam logic [2:0] COND_GT = 3'd3;
	localparam logic [2:0] COND_GE = 3'd4;

	// Result status
	localparam logic [1:0] STATUS_MISS = 2'd0;
	localparam logic [1:0] STATUS_HIT  = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	// Per-cycle action broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	typedef struct packed {
		logic                   compare;
		cell_op_t               op;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} cell_ctrl_t;

endpackage

// ----- rtl/skvt_cell.sv -----
module skvt_cell
	import skvt_pkg::*;
(
	input  logic                   clk,
	input  cell_ctrl_t             ctrl,
	input  logic                   signed_keys,
	input  logic                   occupied,
	input  logic                   left_lt,
	input  logic [KEY_WIDTH-1:0]   left_key,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [KEY_WIDTH-1:0]   right_key,
	input  logic [VALUE_WIDTH-1:0] right_value,
	output logic [KEY_WIDTH-1:0]   key,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   lt,
	output logic                   eq
);

	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   lt_q;
	logic                   eq_q;
	logic [KEY_WIDTH-1:0]   sign_flip;
	logic [KEY_WIDTH-1:0]   own_ord;
	logic [KEY_WIDTH-1:0]   probe_ord;

	// flip the sign bit so an unsigned compare gives the configured order
	assign sign_flip = KEY_WIDTH'(signed_keys) << (KEY_WIDTH - 1);
	assign own_ord   = key_q ^ sign_flip;
	assign probe_ord = ctrl.key ^ sign_flip;

	// compare flags and the shift of the held pair
	// left_lt: every cell to the left compares below the probe
	always_ff @(posedge clk) begin
		if (ctrl.compare) begin
			lt_q <= occupied && (own_ord < probe_ord);
			eq_q <= occupied && (own_ord == probe_ord);
		end
		case (ctrl.op)
			CELL_INSERT: begin
				// cells at or above the insert point move up one place
				if (!(left_lt && lt_q)) begin
					if (left_lt) begin
						key_q   <= ctrl.key;
						value_q <= ctrl.value;
					end else begin
						key_q   <= left_key;
						value_q <= left_value;
					end
				end
			end
			CELL_REMOVE: begin
				if (!(left_lt && lt_q)) begin
					key_q   <= right_key;
					value_q <= right_value;
				end
			end
			CELL_WRITE: begin
				if (left_lt && eq_q) begin
					value_q <= ctrl.value;
				end
			end
			default: begin
			end
		endcase
	end

	assign key   = key_q;
	assign value = value_q;
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

// ----- rtl/sorted_key_value_table.sv -----
// Sorted key/value table of DEPTH entries held in a row of cells, one pair per
// cell, in ascending key order. Each transaction has two steps: in the cycle
// it is accepted every cell compares its key with the probe, and in the execute
// state, which waits while a result is left in the output register, the cells
// shift their pairs one place (insert or remove) or a value is replaced, and the
// selected cell's value is read into the output register. The input is ready
// again once the execute state is done, so a new item is not taken before the
// last one is through. Configuration writes are accepted in any cycle and take
// effect at once.
module sorted_key_value_table
	import skvt_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 command,
	input  logic [KEY_WIDTH-1:0]       key,
	input  logic [VALUE_WIDTH-1:0]     value,
	input  logic [2:0]                 condition,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [VALUE_WIDTH-1:0]     result_value,
	output logic [1:0]                 status,
	output logic [COUNT_WIDTH-1:0]     entries
);

	localparam logic [COUNT_WIDTH-1:0] DEPTH_C = COUNT_WIDTH'(DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                   state_q;
	logic [COUNT_WIDTH-1:0]   capacity_q;
	logic                     signed_q;
	logic [COUNT_WIDTH-1:0]   count_q;
	logic [1:0]               command_q;
	logic [KEY_WIDTH-1:0]     key_q;
	logic [VALUE_WIDTH-1:0]   value_q;
	logic [2:0]               condition_q;
	logic                     out_valid_q;
	logic [VALUE_WIDTH-1:0]   result_q;
	logic [1:0]               status_q;

	logic [KEY_WIDTH-1:0]     key_arr   [DEPTH];
	logic [VALUE_WIDTH-1:0]   value_arr [DEPTH];
	logic [DEPTH-1:0]         lt_vec;
	logic [DEPTH-1:0]         eq_vec;
	logic [DEPTH-1:0]         eq_pos;
	logic [DEPTH-1:0]         occ_vec;
	logic [DEPTH:0]           lt_up;
	logic [DEPTH:0]           lt_dn;
	logic [DEPTH:0]           eq_up;
	logic [DEPTH-1:0]         sel;
	logic [VALUE_WIDTH-1:0]   sel_value;
	logic                     found;
	logic                     hit;
	logic                     full;
	logic [COUNT_WIDTH-1:0]   cap_eff;
	logic                     in_fire;
	logic                     exec_go;
	cell_ctrl_t               ctrl;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign exec_go   = (state_q == ST_EXEC) && (!out_valid_q || out_ready);

	// lt_up[i]: every cell below i compares less, so the probe's place is the
	// first cell where the run of less-than flags ends
	always_comb begin
		lt_up[0] = 1'b1;
		for (int i = 0; i < DEPTH; i++) begin
			lt_up[i+1] = lt_up[i] && lt_vec[i];
		end
	end

	// neighbor views of the compare flags
	assign lt_dn  = {1'b0, lt_vec};
	assign eq_pos = eq_vec & lt_up[DEPTH-1:0];
	assign eq_up  = {eq_pos, 1'b0};

	assign hit     = |eq_pos;
	assign cap_eff = (capacity_q > DEPTH_C) ? DEPTH_C : capacity_q;
	assign full    = (count_q >= cap_eff);

	// cell occupancy from the fill count
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ_vec[i] = (count_q > COUNT_WIDTH'(i));
		end
	end

	// pick the cell that answers the transaction
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			logic at_pos;
			logic below_pos;
			at_pos    = occ_vec[i] && !lt_vec[i] && lt_up[i];
			below_pos = lt_up[i+1] && !lt_dn[i+1];
			sel[i]    = 1'b0;
			case (command_q)
				CMD_PUT, CMD_REMOVE: sel[i] = eq_pos[i];
				CMD_GET: begin
					case (condition_q)
						COND_EQ: sel[i] = eq_pos[i];
						COND_LT: sel[i] = below_pos;
						COND_LE: sel[i] = hit ? eq_pos[i] : below_pos;
						COND_GT: sel[i] = hit ? (occ_vec[i] && eq_up[i]) : at_pos;
						COND_GE: sel[i] = at_pos;
						default: sel[i] = 1'b0;
					endcase
				end
				default: sel[i] = 1'b0;
			endcase
		end
	end

	// read out the selected value
	always_comb begin
		sel_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_value = sel_value | (value_arr[i] & {VALUE_WIDTH{sel[i]}});
		end
	end
	assign found = |sel;

	// action broadcast to the cells
	always_comb begin
		ctrl.compare = in_fire;
		ctrl.key     = in_fire ? key : key_q;
		ctrl.value   = value_q;
		ctrl.op      = CELL_HOLD;
		if (exec_go) begin
			case (command_q)
				CMD_PUT: begin
					if (hit) begin
						ctrl.op = CELL_WRITE;
					end else if (!full) begin
						ctrl.op = CELL_INSERT;
					end
				end
				CMD_REMOVE: begin
					if (hit) begin
						ctrl.op = CELL_REMOVE;
					end
				end
				default: ctrl.op = CELL_HOLD;
			endcase
		end
	end

	// row of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_WIDTH-1:0]   l_key;
		logic [VALUE_WIDTH-1:0] l_value;
		logic [KEY_WIDTH-1:0]   r_key;
		logic [VALUE_WIDTH-1:0] r_value;

		if (g == 0) begin : g_first
			assign l_key   = '0;
			assign l_value = '0;
		end else begin : g_inner_l
			assign l_key   = key_arr[g-1];
			assign l_value = value_arr[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign r_key   = '0;
			assign r_value = '0;
		end else begin : g_inner_r
			assign r_key   = key_arr[g+1];
			assign r_value = value_arr[g+1];
		end

		skvt_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.signed_keys (signed_q),
			.occupied    (occ_vec[g]),
			.left_lt     (lt_up[g]),
			.left_key    (l_key),
			.left_value  (l_value),
			.right_key   (r_key),
			.right_value (r_value),
			.key         (key_arr[g]),
			.value       (value_arr[g]),
			.lt          (lt_vec[g]),
			.eq          (eq_vec[g])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= DEPTH_C;
			signed_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAPACITY: capacity_q <= cfg_data[COUNT_WIDTH-1:0];
				CFG_SIGNED:   signed_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// captured transaction fields
	always_ff @(posedge clk) begin
		if (in_fire) begin
			command_q   <= command;
			key_q       <= key;
			value_q     <= value;
			condition_q <= condition;
		end
		if (exec_go) begin
			result_q <= sel_value;
			if (command_q == CMD_PUT && !hit && full) begin
				status_q <= STATUS_FULL;
			end else if (found) begin
				status_q <= STATUS_HIT;
			end else begin
				status_q <= STATUS_MISS;
			end
		end
	end

	// sequencer, fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces one taken in the same cycle
			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
						if (ctrl.op == CELL_INSERT) begin
							count_q <= count_q + 1'b1;
						end else if (ctrl.op == CELL_REMOVE) begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign entries      = count_q;

	// fill count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above table size");

	// fill count moves by at most one per transaction
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
		count_q == $past(count_q) - 1'b1))
		else $error("entry count jumped");

	// an accepted transaction blocks the input for its execute cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input ready during execute");

	// a full report returns no value
	a_full_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_FULL) |-> (result_q == '0))
		else $error("full status with nonzero value");

endmodule

// ----- tb/sv/sorted_key_value_table_tb.sv -----
module sorted_key_value_table_tb;
	import skvt_pkg::*;

	// Codes the package leaves undefined
	localparam logic [1:0] CMD_UNKNOWN       = 2'd3;
	localparam logic [2:0] COND_RESERVED_LO  = 3'd5;
	localparam logic [2:0] COND_RESERVED_MID = 3'd6;
	localparam logic [2:0] COND_RESERVED_HI  = 3'd7;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT     = 300000;
	localparam int RECV_HOLD_CYCLES = 100;
	localparam int SETTLE_CYCLES   = 4;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] result_value;
		logic [1:0]             status;
		logic [COUNT_WIDTH-1:0] entries;
	} table_reply_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic [1:0]                 command;
	logic [KEY_WIDTH-1:0]       key;
	logic [VALUE_WIDTH-1:0]     value;
	logic [2:0]                 condition;
	logic                       out_valid;
	logic                       out_ready;
	logic [VALUE_WIDTH-1:0]     result_value;
	logic [1:0]                 status;
	logic [COUNT_WIDTH-1:0]     entries;

	// Shadow copy of the table and its registers
	logic [KEY_WIDTH-1:0]   shadow_keys [DEPTH];
	logic [VALUE_WIDTH-1:0] shadow_values [DEPTH];
	int unsigned            shadow_count = 0;
	logic [4:0]             shadow_capacity = 5'd16;
	bit                     shadow_signed = 1'b0;

	table_reply_t pending_replies[$];
	int unsigned  failures = 0;
	int unsigned  cycle_count = 0;

	// Idling control; idle_enable is shared by both sides
	bit          idle_enable = 1'b1;
	bit          recv_hold_request = 1'b0;
	int unsigned recv_hold_left = 0;
	int unsigned recv_stall_left = 0;

	sorted_key_value_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.key         (key),
		.value       (value),
		.condition   (condition),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_value(result_value),
		.status      (status),
		.entries     (entries)
	);

	always #5 clk = ~clk;

	// Key in the configured order, compared as unsigned
	function automatic logic [KEY_WIDTH-1:0] ordered_key(logic [KEY_WIDTH-1:0] k);
		return shadow_signed ? (k ^ {1'b1, {(KEY_WIDTH-1){1'b0}}}) : k;
	endfunction

	// Apply one transaction to the shadow table and return the reply it must produce
	function automatic table_reply_t table_reply_for(logic [1:0] cmd, logic [KEY_WIDTH-1:0] k,
			logic [VALUE_WIDTH-1:0] v, logic [2:0] cond);
		table_reply_t reply;
		int unsigned  pos;
		int unsigned  at;
		int unsigned  cap;
		int unsigned  i;
		bit           hit;
		bit           found;
		reply = '0;
		pos = 0;
		while (pos < shadow_count && ordered_key(shadow_keys[pos]) < ordered_key(k))
			pos++;
		hit = (pos < shadow_count) && (shadow_keys[pos] == k);
		cap = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
		case (cmd)
			CMD_PUT: begin
				if (hit) begin
					reply.result_value = shadow_values[pos];
					reply.status = STATUS_HIT;
					shadow_values[pos] = v;
				end else if (shadow_count >= cap) begin
					reply.status = STATUS_FULL;
				end else begin
					for (i = shadow_count; i > pos; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_values[i] = shadow_values[i-1];
					end
					shadow_keys[pos] = k;
					shadow_values[pos] = v;
					shadow_count++;
				end
			end
			CMD_GET: begin
				found = 1'b0;
				at = 0;
				case (cond)
					COND_EQ: begin
						found = hit;
						at = pos;
					end
					COND_LT: begin
						found = (pos > 0);
						at = pos - 1;
					end
					COND_LE: begin
						found = hit || (pos > 0);
						at = hit ? pos : pos - 1;
					end
					COND_GT: begin
						at = hit ? pos + 1 : pos;
						found = (at < shadow_count);
					end
					COND_GE: begin
						at = pos;
						found = (at < shadow_count);
					end
					default: ;
				endcase
				if (found && at < DEPTH) begin
					reply.result_value = shadow_values[at];
					reply.status = STATUS_HIT;
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					reply.result_value = shadow_values[pos];
					reply.status = STATUS_HIT;
					for (i = pos; i + 1 < shadow_count; i++) begin
						shadow_keys[i] = shadow_keys[i+1];
						shadow_values[i] = shadow_values[i+1];
					end
					shadow_count--;
				end
			end
			default: ;
		endcase
		reply.entries = COUNT_WIDTH'(shadow_count);
		return reply;
	endfunction

	// Send one transaction; valid stays high until the next call or a drain
	task automatic send_item(logic [1:0] cmd, logic [KEY_WIDTH-1:0] k,
			logic [VALUE_WIDTH-1:0] v, logic [2:0] cond);
		int unsigned gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		key <= k;
		value <= v;
		condition <= cond;
		do @(posedge clk); while (!in_ready);
		pending_replies.push_back(table_reply_for(cmd, k, v, cond));
	endtask

	// Stop sending and wait for every outstanding reply
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Key mix: stored keys, their neighbors, corner values and plain random
	function automatic logic [KEY_WIDTH-1:0] pick_key();
		int unsigned sel;
		logic [KEY_WIDTH-1:0] stored;
		sel = $urandom_range(0, 9);
		stored = (shadow_count > 0) ? shadow_keys[$urandom_range(0, shadow_count - 1)] : '0;
		if (sel < 4 && shadow_count > 0)
			return stored;
		if (sel < 6 && shadow_count > 0)
			return $urandom_range(0, 1) ? stored + 1 : stored - 1;
		if (sel < 8) begin
			case ($urandom_range(0, 7))
				0: return 32'h0000_0000;
				1: return 32'h0000_0001;
				2: return 32'h7FFF_FFFF;
				3: return 32'h8000_0000;
				4: return 32'h8000_0001;
				5: return 32'hFFFF_FFFE;
				6: return 32'hFFFF_FFFF;
				default: return $urandom_range(0, 31);
			endcase
		end
		return $urandom;
	endfunction

	task automatic send_random_item();
		logic [1:0]  cmd;
		logic [2:0]  cond;
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			cmd = CMD_PUT;
		else if (sel < 70)
			cmd = CMD_GET;
		else if (sel < 95)
			cmd = CMD_REMOVE;
		else
			cmd = CMD_UNKNOWN;
		if ($urandom_range(0, 9) == 0)
			cond = 3'($urandom_range(COND_RESERVED_LO, COND_RESERVED_HI));
		else
			cond = 3'($urandom_range(COND_EQ, COND_GE));
		send_item(cmd, pick_key(), $urandom, cond);
	endtask

	// Write both registers while idle; stored entries are kept across a change of key order
	task automatic configure(logic [4:0] capacity, bit signed_mode);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_CAPACITY;
		cfg_data <= capacity;
		do @(posedge clk); while (!cfg_ready);
		shadow_capacity = capacity;
		cfg_index <= CFG_SIGNED;
		cfg_data <= {4'($urandom_range(0, 15)), signed_mode};
		do @(posedge clk); while (!cfg_ready);
		shadow_signed = signed_mode;
		// unmapped index, must be ignored
		cfg_index <= CFG_UNUSED;
		cfg_data <= 5'($urandom_range(0, 31));
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed_ops();
		// empty table
		send_item(CMD_GET, 32'h0, 32'h1, COND_EQ);
		send_item(CMD_GET, 32'h0, 32'h2, COND_GE);
		send_item(CMD_REMOVE, 32'h5, 32'h3, COND_EQ);
		// inserts at both ends and in the middle, then a replace
		send_item(CMD_PUT, 32'h8000_0000, 32'hAAAA_5555, COND_EQ);
		send_item(CMD_PUT, 32'h0, 32'hFFFF_FFFF, COND_EQ);
		send_item(CMD_PUT, 32'hFFFF_FFFF, 32'h0, COND_EQ);
		send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h1, COND_EQ);
		send_item(CMD_PUT, 32'h0, 32'h1234_5678, COND_EQ);
		// every match rule, including no predecessor and past the last entry
		send_item(CMD_GET, 32'h0, 32'h0, COND_LT);
		send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0, COND_GT);
		send_item(CMD_GET, 32'h8000_0001, 32'h0, COND_LE);
		send_item(CMD_GET, 32'h8000_0001, 32'h0, COND_GE);
		send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0, COND_GT);
		send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0, COND_LT);
		send_item(CMD_GET, 32'h7FFF_FFFE, 32'h0, COND_EQ);
		send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0, COND_RESERVED_LO);
		send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0, COND_RESERVED_MID);
		send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0, COND_RESERVED_HI);
		send_item(CMD_UNKNOWN, 32'h0, 32'hDEAD_BEEF, COND_EQ);
		// remove a hit, then the same key again
		send_item(CMD_REMOVE, 32'h8000_0000, 32'h0, COND_EQ);
		send_item(CMD_REMOVE, 32'h8000_0000, 32'h0, COND_EQ);
		send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0, COND_EQ);
	endtask

	task automatic test_capacity_limits();
		// capacity below the current count
		configure(5'd1, 1'b0);
		send_item(CMD_PUT, 32'h55, 32'h1, COND_EQ);
		send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h2, COND_EQ);
		send_item(CMD_REMOVE, 32'h0, 32'h0, COND_EQ);
		send_item(CMD_PUT, 32'h66, 32'h3, COND_EQ);
		// capacity zero
		configure(5'd0, 1'b0);
		send_item(CMD_PUT, 32'h77, 32'h4, COND_EQ);
		send_item(CMD_GET, 32'h0, 32'h0, COND_GE);
		// capacity above the depth
		configure(5'd31, 1'b0);
		send_item(CMD_PUT, 32'h77, 32'h5, COND_EQ);
	endtask

	task automatic test_signed_order();
		configure(5'd16, 1'b1);
		send_item(CMD_PUT, 32'h8000_0000, 32'h10, COND_EQ);
		send_item(CMD_PUT, 32'hFFFF_FFFF, 32'h11, COND_EQ);
		send_item(CMD_PUT, 32'h0, 32'h12, COND_EQ);
		send_item(CMD_PUT, 32'h7FFF_FFFF, 32'h13, COND_EQ);
		send_item(CMD_GET, 32'h0, 32'h0, COND_LT);
		send_item(CMD_GET, 32'hFFFF_FFFF, 32'h0, COND_GT);
		send_item(CMD_GET, 32'h8000_0000, 32'h0, COND_LE);
		send_item(CMD_GET, 32'h7FFF_FFFF, 32'h0, COND_GT);
		send_item(CMD_GET, 32'h8000_0000, 32'h0, COND_LT);
	endtask

	// Random traffic; idling switches on and off in stretches
	task automatic test_random_traffic(int unsigned count, logic [4:0] capacity, bit signed_mode);
		configure(capacity, signed_mode);
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 64 == 0)
				idle_enable = ($urandom_range(0, 3) != 0);
			send_random_item();
		end
		idle_enable = 1'b1;
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		drain_results();
		idle_enable = 1'b0;
		recv_hold_request = 1'b1;
		repeat (30) send_random_item();
		drain_results();
		idle_enable = 1'b1;
	endtask

	task automatic test_steady_stream(int unsigned count);
		configure(5'd16, 1'b0);
		idle_enable = 1'b0;
		repeat (count) send_random_item();
	endtask

	// Receiver: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (recv_hold_request) begin
			recv_hold_request = 1'b0;
			recv_hold_left = RECV_HOLD_CYCLES;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (recv_hold_left > 0) begin
			recv_hold_left--;
			out_ready <= 1'b0;
		end else if (recv_stall_left > 0) begin
			recv_stall_left--;
			out_ready <= 1'b0;
		end else if (idle_enable && $urandom_range(0, 5) == 0) begin
			recv_stall_left = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each delivered transaction with the oldest expected reply
	always @(posedge clk) begin : check_replies
		table_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with none expected: value %h status %0d entries %0d",
					$time, result_value, status, entries);
				failures++;
			end else begin
				want = pending_replies.pop_front();
				if (result_value !== want.result_value) begin
					$display("%0t: result_value expected %h actual %h",
						$time, want.result_value, result_value);
					failures++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					failures++;
				end
				if (entries !== want.entries) begin
					$display("%0t: entries expected %0d actual %0d", $time, want.entries, entries);
					failures++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[sorted_key_value_table] ERROR");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_CAPACITY;
		cfg_data = '0;
		in_valid = 1'b0;
		command = CMD_GET;
		key = '0;
		value = '0;
		condition = COND_EQ;
		out_ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_capacity_limits();
		test_signed_order();
		test_random_traffic(300, 5'd16, 1'b0);
		test_random_traffic(250, 5'd4, 1'b1);
		test_backpressure();
		test_random_traffic(300, 5'd31, 1'b0);
		test_random_traffic(100, 5'd0, 1'b0);
		test_random_traffic(300, 5'd1, 1'b1);
		test_random_traffic(300, 5'd16, 1'b1);
		test_steady_stream(250);
		drain_results();

		if (failures == 0)
			$display("[sorted_key_value_table] OK");
		else
			$display("[sorted_key_value_table] ERROR");
		$finish;
	end

endmodule

// ----- sorted_key_value_table.f -----
rtl/skvt_pkg.sv
rtl/skvt_cell.sv
rtl/sorted_key_value_table.sv
tb/sv/sorted_key_value_table_tb.sv
